>>> hw/rtl/dso_pkg.sv
// dso_pkg: shared constants, types and the decay constant table for the
// decaying-statistics outlier flag unit.
// No dependencies.
package dso_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DIV_NUM_W = 64;
    localparam int DIV_DEN_W = 32;
    localparam int SQ_IN_W   = 64;
    localparam int SQ_OUT_W  = 32;
    localparam int CFG_IDX_W = 2;
    localparam int EXP_BITS  = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_MEAN_HL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VAR_HL  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER  = 2'd3;

    localparam logic [31:0] ONE_FX   = 32'h0001_0000;
    localparam logic [47:0] MAX48    = 48'hFFFF_FFFF_FFFF;
    localparam logic [31:0] MAX32    = 32'hFFFF_FFFF;
    localparam logic [32:0] UNITY_Q32 = 33'h1_0000_0000;

    // c[0] = 0.5, c[i] = sqrt(c[i-1]), all with 32 fraction bits
    typedef logic [EXP_BITS:0][31:0] t_ctab;

    function automatic logic [63:0] f_isqrt(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        v = v_in;
        r = '0;
        b = 64'h4000_0000_0000_0000;
        for (int k = 0; k < 32; k++) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic t_ctab f_ctab();
        t_ctab       tab;
        logic [63:0] c;
        c = 64'h8000_0000;
        tab[0] = c[31:0];
        for (int i = 1; i <= EXP_BITS; i++) begin
            c = f_isqrt(c << 32);
            tab[i] = c[31:0];
        end
        return tab;
    endfunction

    localparam t_ctab C_CTAB = f_ctab();

endpackage

>>> hw/rtl/dso_in_if.sv
// dso_in_if: sample input channel (valid/ready plus sample payload).
// No dependencies.
interface dso_in_if;
    logic               valid;
    logic               ready;
    logic        [31:0] timestamp;
    logic signed [31:0] sample_value;

    modport source(output valid, timestamp, sample_value, input ready);
    modport sink(input valid, timestamp, sample_value, output ready);
endinterface

>>> hw/rtl/dso_out_if.sv
// dso_out_if: result channel (valid/ready plus statistics payload).
// No dependencies.
interface dso_out_if;
    logic               valid;
    logic               ready;
    logic        [31:0] echo_time;
    logic signed [31:0] echo_value;
    logic signed [31:0] current_mean;
    logic        [47:0] current_variance;
    logic        [31:0] deviation;
    logic        [31:0] outlier_score;
    logic               is_outlier;

    modport source(output valid, echo_time, echo_value, current_mean, current_variance,
                   deviation, outlier_score, is_outlier, input ready);
    modport sink(input valid, echo_time, echo_value, current_mean, current_variance,
                 deviation, outlier_score, is_outlier, output ready);
endinterface

>>> hw/rtl/decaying_stats_outlier_flag_unit.sv
// decaying_stats_outlier_flag_unit: top level, sequencer around a shared
// multiplier, a restoring divider and a square-root unit.
// Depends on dso_pkg, dso_in_if, dso_out_if, dso_div, dso_sqrt.
//
// Keeps a half-life decayed mean, spread sum and weight of Q16.16 samples and
// flags samples lying more than the cutoff (Q8.8 std devs) from the mean. One
// sample is processed at a time; i_in.ready is high only while idle, and a
// finished result waits in the output register while the next sample is taken.
// The first two samples take one variance/deviation pass; later ones take a
// variance decay, a pass, a mean decay and spread update if accepted and a
// second pass. A zero cutoff skips the score division. Configuration is
// written through i_cfg_we/i_cfg_idx/i_cfg_data and takes effect at once.
module decaying_stats_outlier_flag_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [dso_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [31:0]                   i_cfg_data,
    dso_in_if.sink                        i_in,
    dso_out_if.source                     o_out
);
    import dso_pkg::*;

    typedef enum logic [16:0] {
        ST_IDLE  = 17'h00001,
        ST_DQ    = 17'h00002,
        ST_DE    = 17'h00004,
        ST_DMUL  = 17'h00008,
        ST_DFIN  = 17'h00010,
        ST_WMUL  = 17'h00020,
        ST_VAR   = 17'h00040,
        ST_VARW  = 17'h00080,
        ST_SQ    = 17'h00100,
        ST_DEV   = 17'h00200,
        ST_ROUTE = 17'h00400,
        ST_SC    = 17'h00800,
        ST_MMUL1 = 17'h01000,
        ST_MMUL2 = 17'h02000,
        ST_SMUL1 = 17'h04000,
        ST_SMUL2 = 17'h08000,
        ST_DONE  = 17'h10000
    } t_state;

    t_state r_state;

    // configuration
    logic [31:0] r_mhl, r_vhl;
    logic [15:0] r_cut;
    logic        r_fen;

    // statistics
    logic        [1:0]  r_seen;
    logic        [31:0] r_last;
    logic signed [31:0] r_mean;
    logic        [47:0] r_spread;
    logic        [31:0] r_weight;

    // per-sample working registers
    logic        [31:0] r_t;
    logic signed [31:0] r_y;
    logic        [31:0] r_dt;
    logic        [31:0] r_hl;
    logic        [5:0]  r_q;
    logic        [15:0] r_e;
    logic        [3:0]  r_i;
    logic        [32:0] r_f, r_fv, r_fm;
    logic        [47:0] r_var;
    logic        [31:0] r_dev, r_score;
    logic        [31:0] r_amag;
    logic        [47:0] r_incr;
    logic        [48:0] r_hp;
    logic               r_dsel_mean;   // decay in progress is for the mean
    logic               r_pass_final;  // deviation pass is the reported one

    // shared units
    logic                 r_div_go, r_sq_go;
    logic [DIV_NUM_W-1:0] r_div_num;
    logic [DIV_DEN_W-1:0] r_div_den;
    logic [SQ_IN_W-1:0]   r_sq_val;
    logic                 div_busy, div_done, sq_done;
    logic [DIV_NUM_W-1:0] div_quot;
    logic [DIV_DEN_W-1:0] div_rem;
    logic [SQ_OUT_W-1:0]  sq_root;

    // output register
    logic               r_ovalid;
    logic        [31:0] r_o_time;
    logic signed [31:0] r_o_value, r_o_mean;
    logic        [47:0] r_o_var;
    logic        [31:0] r_o_dev, r_o_score;

    // combinational helpers
    logic        [32:0] mul_a, mul_b;
    logic        [65:0] prod, rnd32, rnd16;
    logic signed [32:0] diff;
    logic        [31:0] mag;
    logic        [32:0] new_mean;
    logic        [31:0] dt_in;
    logic        [47:0] var_q;
    logic        [4:0]  c_idx;
    logic        [33:0] w_next;
    logic        [32:0] avg;
    logic        [49:0] s_scaled;
    logic        [47:0] s_sat;
    logic        [48:0] s_sum;
    logic        [32:0] f_shift;
    logic               upd;

    dso_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_go   (r_div_go),
        .i_num  (r_div_num),
        .i_den  (r_div_den),
        .o_busy (div_busy),
        .o_done (div_done),
        .o_quot (div_quot),
        .o_rem  (div_rem)
    );

    dso_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_go   (r_sq_go),
        .i_val  (r_sq_val),
        .o_done (sq_done),
        .o_root (sq_root)
    );

    always_comb begin
        c_idx = {1'b0, r_i} + 5'd1;
        diff  = $signed({r_mean[31], r_mean}) - $signed({r_y[31], r_y});
        mag   = diff[32] ? 32'(33'd0 - diff) : diff[31:0];
        dt_in = (i_in.timestamp > r_last) ? i_in.timestamp - r_last : '0;
        var_q = (div_quot[63:48] != '0) ? MAX48 : div_quot[47:0];
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            ST_DMUL:  begin mul_a = r_f;                   mul_b = {1'b0, C_CTAB[c_idx]}; end
            ST_WMUL:  begin mul_a = {1'b0, r_weight};      mul_b = r_fv; end
            ST_MMUL1: begin mul_a = {1'b0, mag};           mul_b = r_fm; end
            ST_MMUL2: begin mul_a = {1'b0, r_amag};        mul_b = {1'b0, mag}; end
            ST_SMUL1: begin mul_a = {17'd0, r_spread[47:32]}; mul_b = r_fv; end
            ST_SMUL2: begin mul_a = {1'b0, r_spread[31:0]};   mul_b = r_fv; end
            default:  begin mul_a = '0;                    mul_b = '0; end
        endcase
        prod  = mul_a * mul_b;
        rnd32 = prod + 66'h8000_0000;
        rnd16 = prod + 66'h8000;
        w_next   = {2'b00, rnd32[63:32]} + {2'b00, ONE_FX};
        avg      = $signed({r_mean[31], r_mean}) + $signed({r_y[31], r_y});
        new_mean = diff[32] ? ({r_y[31], r_y} - {1'b0, rnd32[63:32]})
                            : ({r_y[31], r_y} + {1'b0, rnd32[63:32]});
        s_scaled = {1'b0, r_hp} + {17'd0, rnd32[64:32]};
        s_sat    = (s_scaled[49:48] != 2'b00) ? MAX48 : s_scaled[47:0];
        s_sum    = {1'b0, s_sat} + {1'b0, r_incr};
        f_shift  = r_f >> r_q;
        upd      = !r_fen || (r_spread == '0) || (r_dev <= {8'd0, r_cut, 8'd0});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_mhl    <= 32'd1024;
            r_vhl    <= 32'd1024;
            r_cut    <= 16'd768;
            r_fen    <= 1'b1;
            r_seen   <= '0;
            r_last   <= '0;
            r_mean   <= '0;
            r_spread <= {16'd0, ONE_FX};
            r_weight <= '0;
            r_div_go <= 1'b0;
            r_sq_go  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_div_go <= 1'b0;
            r_sq_go  <= 1'b0;
            if (o_out.ready) r_ovalid <= 1'b0;

            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_MEAN_HL: r_mhl <= i_cfg_data;
                    CFG_VAR_HL:  r_vhl <= i_cfg_data;
                    CFG_CUTOFF:  r_cut <= i_cfg_data[15:0];
                    CFG_FILTER:  r_fen <= i_cfg_data[0];
                endcase
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (i_in.valid) begin
                        r_t  <= i_in.timestamp;
                        r_y  <= i_in.sample_value;
                        r_dt <= dt_in;
                        r_dsel_mean <= 1'b0;
                        if (r_seen == 2'd2) begin
                            r_hl      <= (r_vhl == '0) ? 32'd1 : r_vhl;
                            r_div_num <= {32'd0, dt_in};
                            r_div_den <= (r_vhl == '0) ? 32'd1 : r_vhl;
                            r_div_go  <= 1'b1;
                            r_state   <= ST_DQ;
                        end else begin
                            r_fv    <= UNITY_Q32;
                            r_state <= ST_WMUL;
                        end
                    end
                end
                ST_DQ: begin
                    if (div_done) begin
                        if (div_quot > 64'd32) begin
                            r_f     <= '0;
                            r_q     <= '0;
                            r_state <= ST_DFIN;
                        end else begin
                            r_q       <= div_quot[5:0];
                            r_div_num <= {16'd0, div_rem, 16'd0};
                            r_div_den <= r_hl;
                            r_div_go  <= 1'b1;
                            r_state   <= ST_DE;
                        end
                    end
                end
                ST_DE: begin
                    if (div_done) begin
                        r_e     <= div_quot[15:0];
                        r_f     <= UNITY_Q32;
                        r_i     <= '0;
                        r_state <= ST_DMUL;
                    end
                end
                ST_DMUL: begin
                    // one factor per set fraction bit: 0.5 raised to that bit's weight
                    if (r_e[4'd15 - r_i]) r_f <= rnd32[64:32];
                    r_i <= r_i + 1'b1;
                    if (r_i == 4'd15) r_state <= ST_DFIN;
                end
                ST_DFIN: begin
                    if (r_dsel_mean) begin
                        r_fm    <= f_shift;
                        r_state <= ST_MMUL1;
                    end else begin
                        r_fv    <= f_shift;
                        r_state <= ST_WMUL;
                    end
                end
                ST_WMUL: begin
                    r_weight <= (w_next[33:32] != 2'b00) ? MAX32 : w_next[31:0];
                    unique case (r_seen)
                        2'd0: begin
                            r_mean       <= r_y;
                            r_spread     <= {16'd0, ONE_FX};
                            r_pass_final <= 1'b1;
                        end
                        2'd1: begin
                            r_mean       <= avg[32:1];
                            r_spread     <= {16'd0, ONE_FX};
                            r_pass_final <= 1'b1;
                        end
                        default: r_pass_final <= 1'b0;
                    endcase
                    r_state <= ST_VAR;
                end
                ST_VAR: begin
                    r_div_num <= {r_spread, 16'd0};
                    r_div_den <= r_weight;
                    r_div_go  <= 1'b1;
                    r_state   <= ST_VARW;
                end
                ST_VARW: begin
                    if (div_done) begin
                        r_var    <= var_q;
                        r_sq_val <= {var_q, 16'd0};
                        r_sq_go  <= 1'b1;
                        r_state  <= ST_SQ;
                    end
                end
                ST_SQ: begin
                    if (sq_done) begin
                        if (sq_root == '0) begin
                            r_dev   <= MAX32;
                            r_state <= ST_ROUTE;
                        end else begin
                            r_div_num <= {16'd0, mag, 16'd0};
                            r_div_den <= sq_root;
                            r_div_go  <= 1'b1;
                            r_state   <= ST_DEV;
                        end
                    end
                end
                ST_DEV: begin
                    if (div_done) begin
                        r_dev   <= (div_quot[63:32] != '0) ? MAX32 : div_quot[31:0];
                        r_state <= ST_ROUTE;
                    end
                end
                ST_ROUTE: begin
                    if (!r_pass_final) begin
                        if (upd) begin
                            r_dsel_mean <= 1'b1;
                            r_hl        <= (r_mhl == '0) ? 32'd1 : r_mhl;
                            r_div_num   <= {32'd0, r_dt};
                            r_div_den   <= (r_mhl == '0) ? 32'd1 : r_mhl;
                            r_div_go    <= 1'b1;
                            r_state     <= ST_DQ;
                        end else begin
                            r_pass_final <= 1'b1;
                            r_state      <= ST_VAR;
                        end
                    end else if (r_cut == '0) begin
                        r_score <= (r_dev == '0) ? '0 : MAX32;
                        r_state <= ST_DONE;
                    end else begin
                        r_div_num <= {24'd0, r_dev, 8'd0};
                        r_div_den <= {16'd0, r_cut};
                        r_div_go  <= 1'b1;
                        r_state   <= ST_SC;
                    end
                end
                ST_SC: begin
                    if (div_done) begin
                        r_score <= (div_quot[63:32] != '0) ? MAX32 : div_quot[31:0];
                        r_state <= ST_DONE;
                    end
                end
                ST_MMUL1: begin
                    r_mean  <= new_mean[31:0];
                    r_amag  <= mag;
                    r_state <= ST_MMUL2;
                end
                ST_MMUL2: begin
                    r_incr  <= (rnd16[65:64] != 2'b00) ? MAX48 : rnd16[63:16];
                    r_state <= ST_SMUL1;
                end
                ST_SMUL1: begin
                    r_hp    <= prod[48:0];
                    r_state <= ST_SMUL2;
                end
                ST_SMUL2: begin
                    r_spread     <= s_sum[48] ? MAX48 : s_sum[47:0];
                    r_pass_final <= 1'b1;
                    r_state      <= ST_VAR;
                end
                ST_DONE: begin
                    // result register free or being emptied this cycle
                    if (!r_ovalid || o_out.ready) begin
                        r_ovalid  <= 1'b1;
                        r_o_time  <= r_t;
                        r_o_value <= r_y;
                        r_o_mean  <= r_mean;
                        r_o_var   <= r_var;
                        r_o_dev   <= r_dev;
                        r_o_score <= r_score;
                        if (r_seen != 2'd2) r_seen <= r_seen + 1'b1;
                        r_last  <= r_t;
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign i_in.ready             = (r_state == ST_IDLE);
    assign o_out.valid            = r_ovalid;
    assign o_out.echo_time        = r_o_time;
    assign o_out.echo_value       = r_o_value;
    assign o_out.current_mean     = r_o_mean;
    assign o_out.current_variance = r_o_var;
    assign o_out.deviation        = r_o_dev;
    assign o_out.outlier_score    = r_o_score;
    assign o_out.is_outlier       = (r_o_score > ONE_FX);

    a_seen_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen != 2'd3)
        else $error("sample count past saturation");

    a_weight_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && r_seen != 2'd0) |-> (r_weight >= ONE_FX))
        else $error("weight below one after a sample");

    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !div_busy)
        else $error("divider still busy while idle");

endmodule

>>> hw/rtl/dso_div.sv
// dso_div: restoring unsigned divider, one quotient bit per cycle.
// Depends on dso_pkg.
module dso_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_go,
    input  logic [dso_pkg::DIV_NUM_W-1:0] i_num,
    input  logic [dso_pkg::DIV_DEN_W-1:0] i_den,
    output logic                          o_busy,
    output logic                          o_done,
    output logic [dso_pkg::DIV_NUM_W-1:0] o_quot,
    output logic [dso_pkg::DIV_DEN_W-1:0] o_rem
);
    import dso_pkg::*;

    logic [DIV_NUM_W-1:0]         r_dq;
    logic [DIV_DEN_W:0]           r_rem;
    logic [DIV_DEN_W-1:0]         r_den;
    logic [$clog2(DIV_NUM_W)-1:0] r_cnt;
    logic                         r_busy;
    logic                         r_done;
    logic [DIV_DEN_W:0]           rem_sh;
    logic                         fits;

    assign rem_sh = {r_rem[DIV_DEN_W-1:0], r_dq[DIV_NUM_W-1]};
    assign fits   = rem_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_dq   <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= fits ? rem_sh - {1'b0, r_den} : rem_sh;
                r_dq  <= {r_dq[DIV_NUM_W-2:0], fits};
                r_cnt <= r_cnt + 1'b1;
                if (&r_cnt) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_dq;
    assign o_rem  = r_rem[DIV_DEN_W-1:0];
endmodule

>>> hw/rtl/dso_sqrt.sv
// dso_sqrt: floor square root, one result bit per cycle.
// Depends on dso_pkg.
module dso_sqrt (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_go,
    input  logic [dso_pkg::SQ_IN_W-1:0]  i_val,
    output logic                         o_done,
    output logic [dso_pkg::SQ_OUT_W-1:0] o_root
);
    import dso_pkg::*;

    logic [SQ_IN_W-1:0]          r_v;
    logic [SQ_IN_W-1:0]          r_r;
    logic [SQ_IN_W-1:0]          r_b;
    logic [$clog2(SQ_OUT_W)-1:0] r_cnt;
    logic                        r_busy;
    logic                        r_done;
    logic [SQ_IN_W-1:0]          trial;

    assign trial = r_r + r_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_v    <= i_val;
                r_r    <= '0;
                r_b    <= {2'b01, {(SQ_IN_W-2){1'b0}}};
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_v >= trial) begin
                    r_v <= r_v - trial;
                    r_r <= (r_r >> 1) + r_b;
                end else begin
                    r_r <= r_r >> 1;
                end
                r_b   <= r_b >> 2;
                r_cnt <= r_cnt + 1'b1;
                if (&r_cnt) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_r[SQ_OUT_W-1:0];
endmodule
